// ----- rtl/stcf_pkg.sv -----
`timescale 1ns / 1ps

package stcf_pkg;

    localparam int LINE_CAP = 10;
    localparam int FILL_W   = $clog2(LINE_CAP + 1);

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [2:0] RESP_NONE  = 3'd0;
    localparam logic [2:0] RESP_CLEAR = 3'd1;
    localparam logic [2:0] RESP_ER001 = 3'd2;
    localparam logic [2:0] RESP_ER002 = 3'd3;
    localparam logic [2:0] RESP_OK    = 3'd4;

    localparam logic [1:0] MODE_RX_ONLY = 2'd0;
    localparam logic [1:0] MODE_TX_ONLY = 2'd1;
    localparam logic [1:0] MODE_RX_TX   = 2'd2;
    localparam logic [1:0] MODE_RESET   = MODE_RX_TX;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [2:0] response;
        logic       request_tx;
    } result_t;

endpackage

// ----- rtl/stcf_parser.sv -----
`timescale 1ns / 1ps

module stcf_parser
    import stcf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic [1:0]    link_mode,
    output logic          res_valid,
    output result_t       res
);

    localparam logic PH_CMD     = 1'b0;
    localparam logic PH_PAYLOAD = 1'b1;

    logic              phase_reg, phase_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              prev_cr_reg, prev_cr_next;
    logic              t_first_reg, t_first_next;
    logic              tx_prefix_reg, tx_prefix_next;
    logic [7:0]        len_reg, len_next;
    logic              len_run_reg, len_run_next;
    logic [7:0]        total_reg, total_next;
    logic [7:0]        seen_reg, seen_next;

    logic              tx_allowed;
    logic              is_digit;
    logic [7:0]        digit;
    logic [7:0]        len_step;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]        seen_inc;
    logic              crlf;

    assign tx_allowed = (link_mode == MODE_TX_ONLY) || (link_mode == MODE_RX_TX);
    assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit      = in_byte - CH_ZERO;
    assign len_step   = {len_reg[4:0], 3'b000} + {len_reg[6:0], 1'b0} + digit;
    assign fill_inc   = fill_reg + {{(FILL_W-1){1'b0}}, 1'b1};
    assign seen_inc   = seen_reg + 8'd1;
    assign crlf       = (fill_reg != '0) && prev_cr_reg && (in_byte == CH_LF);

    always_comb
    begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        prev_cr_next   = prev_cr_reg;
        t_first_next   = t_first_reg;
        tx_prefix_next = tx_prefix_reg;
        len_next       = len_reg;
        len_run_next   = len_run_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_valid         = 1'b1;
                    res.payload_valid = 1'b1;
                    res.payload_byte  = in_byte;
                    seen_next         = seen_inc;
                    if (seen_inc == total_reg)
                    begin
                        res.response = RESP_OK;
                        res.request_tx = tx_allowed;
                        phase_next   = PH_CMD;
                        seen_next    = '0;
                    end
                end
                PH_CMD:
                begin
                    fill_next    = fill_inc;
                    prev_cr_next = (in_byte == CH_CR);
                    if (fill_reg == FILL_W'(0))
                        t_first_next = (in_byte == CH_T);
                    if (fill_reg == FILL_W'(1))
                        tx_prefix_next = t_first_reg && (in_byte == CH_X);
                    if (fill_reg == FILL_W'(2))
                    begin
                        len_run_next = is_digit;
                        len_next     = is_digit ? digit : 8'd0;
                    end
                    else if ((fill_reg == FILL_W'(3)) || (fill_reg == FILL_W'(4)))
                    begin
                        if (len_run_reg && is_digit)
                            len_next = len_step;
                        else
                            len_run_next = 1'b0;
                    end

                    if (crlf)
                    begin
                        fill_next = '0;
                        if (fill_reg == FILL_W'(1))
                        begin
                            res_valid    = 1'b1;
                            res.response = RESP_CLEAR;
                        end
                        else if (tx_prefix_reg)
                        begin
                            seen_next = '0;
                            if (len_reg == 8'd0)
                            begin
                                total_next     = '0;
                                res_valid      = 1'b1;
                                res.response   = RESP_OK;
                                res.request_tx = tx_allowed;
                            end
                            else
                            begin
                                total_next = len_reg;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            res.response = RESP_ER001;
                        end
                    end
                    else if (fill_inc >= FILL_W'(LINE_CAP))
                    begin
                        fill_next    = '0;
                        res_valid    = 1'b1;
                        res.response = RESP_ER002;
                    end
                end
                default:
                begin
                    phase_next = PH_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            fill_reg      <= '0;
            prev_cr_reg   <= 1'b0;
            t_first_reg   <= 1'b0;
            tx_prefix_reg <= 1'b0;
            len_run_reg   <= 1'b0;
            total_reg     <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            prev_cr_reg   <= prev_cr_next;
            t_first_reg   <= t_first_next;
            tx_prefix_reg <= tx_prefix_next;
            len_run_reg   <= len_run_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

// ----- rtl/stcf_out_reg.sv -----
`timescale 1ns / 1ps

module stcf_out_reg
    import stcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    hold,
    output result_t word
);

    logic    valid_reg, valid_next;
    result_t word_reg;

    assign hold = valid_reg && out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= res;
    end

    assign out_valid = valid_reg;
    assign word      = word_reg;

endmodule

// ----- rtl/serial_tx_command_framer_core.sv -----
`timescale 1ns / 1ps

// Terminal command framer: takes one byte per cycle and answers in the next cycle.
// The parser handles each byte combinationally; its result word (if any) lands in
// an output register the cycle after acceptance; a new byte is taken every cycle
// unless a finished word waits under out_stall. Command lines of up to LINE_CAP
// bytes are tracked with a few flags and a running length, so no clearing pass is
// needed after reset. A CR LF line answers CLEAR, a TX line with a decimal length
// enters payload phase (length 0 gives OK at once), other lines answer ER001 and a
// full unterminated line answers ER002. Payload bytes are passed out one word each;
// the last one carries OK and a transmit request when link_mode permits. link_mode
// must be written through the cfg port while idle; the block does not enforce it.

module serial_tx_command_framer_core
    import stcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [2:0] response,
    output logic       request_tx,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] link_mode
);

    logic [1:0] link_mode_reg;
    logic       accept;
    logic       res_valid;
    logic       hold;
    result_t    res;
    result_t    word;

    assign cfg_ready = 1'b1;
    assign in_stall  = hold;
    assign accept    = in_valid && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_mode_reg <= MODE_RESET;
        else if (cfg_valid && cfg_ready)
            link_mode_reg <= link_mode;
    end

    stcf_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .link_mode (link_mode_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    stcf_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .hold      (hold),
        .word      (word)
    );

    assign payload_valid = word.payload_valid;
    assign payload_byte  = word.payload_byte;
    assign response      = word.response;
    assign request_tx    = word.request_tx;

    a_req_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_tx |-> response == RESP_OK)
        else $error("transmit request without OK");

    a_cmd_word_has_resp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> response != RESP_NONE && payload_byte == 8'd0)
        else $error("empty command word");

    a_resp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> response <= RESP_OK)
        else $error("response code out of range");

    a_no_req_rx_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && link_mode_reg == MODE_RX_ONLY |=> !(out_valid && request_tx))
        else $error("transmit request in receive only mode");

endmodule
